// ===== src/wave_dispersion_solver_assert.svh =====
// Assertion helpers included by the checker file.
`ifndef WAVE_DISPERSION_SOLVER_ASSERT_SVH
`define WAVE_DISPERSION_SOLVER_ASSERT_SVH

// Concurrent assertion on a given clock and active-low reset.
`define WDS_ASSERT_ON(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, on the block clock and reset.
`define WDS_ASSERT(lbl, prop, msg) `WDS_ASSERT_ON(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== src/wds_pkg.sv =====
`timescale 1ns / 1ps
package wds_pkg;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned DEPTH_W  = 20;
  localparam int unsigned GRAV_W   = 20;
  localparam int unsigned K_W      = 32;
  localparam int unsigned L_W      = 24;
  localparam int unsigned C_W      = 16;
  localparam int unsigned KIND_W   = 2;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [DEPTH_W-1:0]  depth;
  } in_t;

  typedef struct packed {
    logic [K_W-1:0]    wave_number;
    logic [L_W-1:0]    wave_length;
    logic [C_W-1:0]    celerity;
    logic [KIND_W-1:0] sea_kind;
    logic              saturated;
  } out_t;

  localparam logic [KIND_W-1:0] SEA_SHALLOW = 2'd0;
  localparam logic [KIND_W-1:0] SEA_MID     = 2'd1;
  localparam logic [KIND_W-1:0] SEA_DEEP    = 2'd2;

  localparam logic [GRAV_W-1:0] GRAVITY_RESET = 20'd642908;

  localparam logic [K_W-1:0] K_MAX = 32'hFFFF_FFFF;
  localparam logic [L_W-1:0] L_MAX = 24'hFF_FFFF;
  localparam logic [C_W-1:0] C_MAX = 16'hFFFF;

  // 4*pi^2 in Q.32, 2*pi in Q.36
  localparam logic [37:0] FOUR_PI_SQ_Q32 = 38'd169558512509;
  localparam logic [38:0] TWO_PI_Q36     = 39'd431777206544;

  localparam int unsigned HORNER_STEPS = 6;
  localparam logic [62:0] ACC_CAP = {63{1'b1}};
  localparam logic [62:0] CF6     = 63'd28092515;

  // Horner coefficients after the leading one, Q.32
  function automatic logic [62:0] horner_coef(input logic [2:0] step);
    logic [62:0] c;
    unique case (step)
      3'd0:    c = 63'd93432926;
      3'd1:    c = 63'd271484352;
      3'd2:    c = 63'd690830718;
      3'd3:    c = 63'd1527099483;
      3'd4:    c = 63'd2863311530;
      default: c = 63'd4294967296;
    endcase
    return c;
  endfunction

endpackage

// ===== src/wds_div.sv =====
`timescale 1ns / 1ps
module wds_div #(
  parameter int unsigned D_W = 32,
  parameter int unsigned Q_W = 32,
  parameter int unsigned S_W = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [D_W-1:0] rem_i,
  input  logic [Q_W-1:0] low_i,
  input  logic [D_W-1:0] div_i,
  input  logic [S_W-1:0] side_i,
  output logic           valid_o,
  output logic [Q_W-1:0] quo_o,
  output logic [S_W-1:0] side_o
);

  // Restoring division, one quotient bit per stage. The word shifts the
  // numerator bits out at the top and the quotient bits in at the bottom.
  logic           valid_q [Q_W];
  logic [D_W-1:0] rem_q   [Q_W];
  logic [D_W-1:0] div_q   [Q_W];
  logic [Q_W-1:0] word_q  [Q_W];
  logic [S_W-1:0] side_q  [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic           v_p;
    logic [D_W-1:0] rem_p;
    logic [D_W-1:0] div_p;
    logic [Q_W-1:0] word_p;
    logic [S_W-1:0] side_p;
    logic [D_W:0]   trial;
    logic           take;

    if (i == 0) begin : g_first
      assign v_p    = valid_i;
      assign rem_p  = rem_i;
      assign div_p  = div_i;
      assign word_p = low_i;
      assign side_p = side_i;
    end else begin : g_next
      assign v_p    = valid_q[i-1];
      assign rem_p  = rem_q[i-1];
      assign div_p  = div_q[i-1];
      assign word_p = word_q[i-1];
      assign side_p = side_q[i-1];
    end

    assign trial = {rem_p, word_p[Q_W-1]};
    assign take  = trial >= {1'b0, div_p};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (en_i) begin
        valid_q[i] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= take ? D_W'(trial - {1'b0, div_p}) : trial[D_W-1:0];
        div_q[i]  <= div_p;
        word_q[i] <= {word_p[Q_W-2:0], take};
        side_q[i] <= side_p;
      end
    end
  end

  assign valid_o = valid_q[Q_W-1];
  assign quo_o   = word_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

// ===== src/wave_dispersion_solver.sv =====
// Throughput: one request per cycle; the whole pipeline holds while the output stalls.
// Depth is set by the five one-bit-per-stage divider chains and the 64-stage square root.
// Reset clears all valid bits and sets gravity to 9.81 m/s^2; no clearing pass.
`timescale 1ns / 1ps
module wave_dispersion_solver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  wds_pkg::in_t                in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output wds_pkg::out_t               out_rsp_o,
  input  logic                        cfg_we_i,
  input  logic [wds_pkg::GRAV_W-1:0]  cfg_wdata_i
);
  import wds_pkg::*;

  typedef struct packed {
    logic [PERIOD_W-1:0] per;
    logic [DEPTH_W-1:0]  dep;
    logic                bad;
  } ctx_t;

  typedef struct packed {
    logic [63:0] y;
    ctx_t        c;
  } yctx_t;

  typedef struct packed {
    logic [K_W-1:0]      k;
    logic [PERIOD_W-1:0] per;
    logic [DEPTH_W-1:0]  dep;
    logic                sat;
    logic                clip;
  } kctx_t;

  typedef struct packed {
    logic [K_W-1:0]    k;
    logic [L_W-1:0]    len;
    logic [KIND_W-1:0] kind;
    logic              sat;
    logic              clip;
  } octx_t;

  logic en;
  logic out_valid_q;
  out_t out_rsp_q;
  logic [GRAV_W-1:0] gravity_q;

  assign en          = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q <= GRAVITY_RESET;
    end else if (cfg_we_i) begin
      gravity_q <= cfg_wdata_i;
    end
  end

  // front end: numerator and denominator of y
  logic                p1_v_q, p2_v_q, p3_v_q;
  logic [PERIOD_W-1:0] p1_per_q, p2_per_q;
  logic [DEPTH_W-1:0]  p1_dep_q, p2_dep_q;
  logic [35:0]         p1_gp_q;
  logic [57:0]         p1_num_q, p2_num_q, p3_num_q;
  logic [51:0]         p2_den_q, p3_den_q;
  ctx_t                p3_ctx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q <= in_valid_i;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_per_q     <= in_req_i.period;
      p1_dep_q     <= in_req_i.depth;
      p1_gp_q      <= gravity_q * in_req_i.period;
      p1_num_q     <= FOUR_PI_SQ_Q32 * in_req_i.depth;
      p2_per_q     <= p1_per_q;
      p2_dep_q     <= p1_dep_q;
      p2_num_q     <= p1_num_q;
      p2_den_q     <= p1_gp_q * p1_per_q;
      p3_num_q     <= p2_num_q;
      p3_den_q     <= p2_den_q;
      p3_ctx_q.per <= p2_per_q;
      p3_ctx_q.dep <= p2_dep_q;
      p3_ctx_q.bad <= ({14'd0, p2_num_q[57:20]} >= p2_den_q) || (p2_dep_q == '0);
    end
  end

  // y = 4pi^2 h 2^44 / (g T^2), Q16.48
  logic                    d1_v;
  logic [63:0]             d1_y;
  logic [$bits(ctx_t)-1:0] d1_side;

  wds_div #(.D_W(52), .Q_W(64), .S_W($bits(ctx_t))) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p3_v_q),
    .rem_i   ({14'd0, p3_num_q[57:20]}),
    .low_i   ({p3_num_q[19:0], 44'd0}),
    .div_i   (p3_den_q),
    .side_i  (p3_ctx_q),
    .valid_o (d1_v),
    .quo_o   (d1_y),
    .side_o  (d1_side)
  );

  // Horner evaluation of k1, three stages a step
  logic        ha_v_q  [HORNER_STEPS];
  yctx_t       ha_x_q  [HORNER_STEPS];
  logic [63:0] ha_ll_q [HORNER_STEPS];
  logic [63:0] ha_lh_q [HORNER_STEPS];
  logic [62:0] ha_hl_q [HORNER_STEPS];
  logic [62:0] ha_hh_q [HORNER_STEPS];
  logic        hb_v_q  [HORNER_STEPS];
  yctx_t       hb_x_q  [HORNER_STEPS];
  logic [127:0] hb_p_q [HORNER_STEPS];
  logic        hc_v_q  [HORNER_STEPS];
  yctx_t       hc_x_q  [HORNER_STEPS];
  logic [62:0] hc_acc_q [HORNER_STEPS];

  for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_horner
    logic        v_in;
    yctx_t       x_in;
    logic [62:0] acc_in;
    logic [62:0] coef;
    logic [63:0] prod_mid;
    logic        cap;

    if (j == 0) begin : g_first
      assign v_in   = d1_v;
      assign x_in   = {d1_y, d1_side};
      assign acc_in = CF6;
    end else begin : g_next
      assign v_in   = hc_v_q[j-1];
      assign x_in   = hc_x_q[j-1];
      assign acc_in = hc_acc_q[j-1];
    end

    assign coef     = horner_coef(3'(j));
    assign prod_mid = hb_p_q[j][111:48];
    assign cap      = (hb_p_q[j][127:112] != '0) || (prod_mid > {1'b0, ACC_CAP - coef});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ha_v_q[j] <= 1'b0;
        hb_v_q[j] <= 1'b0;
        hc_v_q[j] <= 1'b0;
      end else if (en) begin
        ha_v_q[j] <= v_in;
        hb_v_q[j] <= ha_v_q[j];
        hc_v_q[j] <= hb_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        ha_x_q[j]   <= x_in;
        ha_ll_q[j]  <= acc_in[31:0] * x_in.y[31:0];
        ha_lh_q[j]  <= acc_in[31:0] * x_in.y[63:32];
        ha_hl_q[j]  <= acc_in[62:32] * x_in.y[31:0];
        ha_hh_q[j]  <= acc_in[62:32] * x_in.y[63:32];
        hb_x_q[j]   <= ha_x_q[j];
        hb_p_q[j]   <= {64'd0, ha_ll_q[j]} + {32'd0, ha_lh_q[j], 32'd0}
                     + {33'd0, ha_hl_q[j], 32'd0} + {1'b0, ha_hh_q[j], 64'd0};
        hc_x_q[j]   <= hb_x_q[j];
        hc_acc_q[j] <= cap ? ACC_CAP : 63'(prod_mid + {1'b0, coef});
      end
    end
  end

  // t = y 2^32 / k1, Q.48
  logic                     d2_v;
  logic [63:0]              d2_t;
  logic [$bits(yctx_t)-1:0] d2_side;
  yctx_t                    d2_x;

  wds_div #(.D_W(63), .Q_W(64), .S_W($bits(yctx_t))) u_div_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (hc_v_q[HORNER_STEPS-1]),
    .rem_i   ({31'd0, hc_x_q[HORNER_STEPS-1].y[63:32]}),
    .low_i   ({hc_x_q[HORNER_STEPS-1].y[31:0], 32'd0}),
    .div_i   (hc_acc_q[HORNER_STEPS-1]),
    .side_i  (hc_x_q[HORNER_STEPS-1]),
    .valid_o (d2_v),
    .quo_o   (d2_t),
    .side_o  (d2_side)
  );

  assign d2_x = d2_side;

  // s = y^2 / 4 + t 2^46, Q.94
  logic         sa_v_q, sb_v_q, sc_v_q;
  ctx_t         sa_c_q, sb_c_q, sc_c_q;
  logic [63:0]  sa_t_q, sb_t_q;
  logic [63:0]  sa_ll_q, sa_lh_q, sa_hl_q, sa_hh_q;
  logic [127:0] sb_sq_q, sc_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_v_q <= 1'b0;
      sb_v_q <= 1'b0;
      sc_v_q <= 1'b0;
    end else if (en) begin
      sa_v_q <= d2_v;
      sb_v_q <= sa_v_q;
      sc_v_q <= sb_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_c_q  <= d2_x.c;
      sa_t_q  <= d2_t;
      sa_ll_q <= d2_x.y[31:0] * d2_x.y[31:0];
      sa_lh_q <= d2_x.y[31:0] * d2_x.y[63:32];
      sa_hl_q <= d2_x.y[63:32] * d2_x.y[31:0];
      sa_hh_q <= d2_x.y[63:32] * d2_x.y[63:32];
      sb_c_q  <= sa_c_q;
      sb_t_q  <= sa_t_q;
      sb_sq_q <= {64'd0, sa_ll_q} + {32'd0, sa_lh_q, 32'd0}
               + {32'd0, sa_hl_q, 32'd0} + {sa_hh_q, 64'd0};
      sc_c_q  <= sb_c_q;
      sc_s_q  <= {2'd0, sb_sq_q[127:2]} + {18'd0, sb_t_q, 46'd0};
    end
  end

  // floor square root, one root bit per stage
  localparam int unsigned ROOT_W = 64;
  logic              sr_v_q    [ROOT_W];
  ctx_t              sr_c_q    [ROOT_W];
  logic [65:0]       sr_rem_q  [ROOT_W];
  logic [ROOT_W-1:0] sr_root_q [ROOT_W];
  logic [127:0]      sr_s_q    [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_root
    logic              v_p;
    ctx_t              c_p;
    logic [65:0]       rem_p;
    logic [ROOT_W-1:0] root_p;
    logic [127:0]      s_p;
    logic [67:0]       x;
    logic [67:0]       trial;
    logic              take;

    if (i == 0) begin : g_first
      assign v_p    = sc_v_q;
      assign c_p    = sc_c_q;
      assign rem_p  = '0;
      assign root_p = '0;
      assign s_p    = sc_s_q;
    end else begin : g_next
      assign v_p    = sr_v_q[i-1];
      assign c_p    = sr_c_q[i-1];
      assign rem_p  = sr_rem_q[i-1];
      assign root_p = sr_root_q[i-1];
      assign s_p    = sr_s_q[i-1];
    end

    assign x     = {rem_p, s_p[127:126]};
    assign trial = {2'd0, root_p, 2'b01};
    assign take  = x >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sr_v_q[i] <= 1'b0;
      end else if (en) begin
        sr_v_q[i] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sr_c_q[i]    <= c_p;
        sr_rem_q[i]  <= take ? 66'(x - trial) : x[65:0];
        sr_root_q[i] <= {root_p[ROOT_W-2:0], take};
        sr_s_q[i]    <= {s_p[125:0], 2'b00};
      end
    end
  end

  // k = kh / (h 2^11)
  logic        k0_v_q;
  ctx_t        k0_c_q;
  logic [63:0] k0_kh_q;
  logic [30:0] k0_d_q;
  logic [30:0] k0_d;

  assign k0_d = {sr_c_q[ROOT_W-1].dep, 11'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k0_v_q <= 1'b0;
    end else if (en) begin
      k0_v_q <= sr_v_q[ROOT_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      k0_kh_q    <= sr_root_q[ROOT_W-1];
      k0_d_q     <= k0_d;
      k0_c_q.per <= sr_c_q[ROOT_W-1].per;
      k0_c_q.dep <= sr_c_q[ROOT_W-1].dep;
      k0_c_q.bad <= sr_c_q[ROOT_W-1].bad
                    || (sr_root_q[ROOT_W-1][63:32] >= {1'b0, k0_d});
    end
  end

  logic                    d3_v;
  logic [K_W-1:0]          d3_k;
  logic [$bits(ctx_t)-1:0] d3_side;
  ctx_t                    d3_c;

  wds_div #(.D_W(31), .Q_W(K_W), .S_W($bits(ctx_t))) u_div_k (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (k0_v_q),
    .rem_i   (k0_kh_q[62:32]),
    .low_i   (k0_kh_q[31:0]),
    .div_i   (k0_d_q),
    .side_i  (k0_c_q),
    .valid_o (d3_v),
    .quo_o   (d3_k),
    .side_o  (d3_side)
  );

  assign d3_c = d3_side;

  logic  k1_v_q;
  kctx_t k1_q;
  kctx_t k1_fwd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k1_v_q <= 1'b0;
    end else if (en) begin
      k1_v_q <= d3_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      k1_q.k    <= d3_c.bad ? K_MAX : d3_k;
      k1_q.per  <= d3_c.per;
      k1_q.dep  <= d3_c.dep;
      k1_q.sat  <= d3_c.bad;
      k1_q.clip <= 1'b0;
    end
  end

  // L = 2pi 2^4 / k
  always_comb begin
    k1_fwd      = k1_q;
    k1_fwd.clip = k1_q.k <= {17'd0, TWO_PI_Q36[38:24]};
  end

  logic                     d4_v;
  logic [L_W-1:0]           d4_len;
  logic [$bits(kctx_t)-1:0] d4_side;
  kctx_t                    d4_c;

  wds_div #(.D_W(K_W), .Q_W(L_W), .S_W($bits(kctx_t))) u_div_len (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (k1_v_q),
    .rem_i   ({17'd0, TWO_PI_Q36[38:24]}),
    .low_i   (TWO_PI_Q36[23:0]),
    .div_i   (k1_q.k),
    .side_i  (k1_fwd),
    .valid_o (d4_v),
    .quo_o   (d4_len),
    .side_o  (d4_side)
  );

  assign d4_c = d4_side;

  logic                l1_v_q;
  logic [K_W-1:0]      l1_k_q;
  logic [L_W-1:0]      l1_len_q;
  logic [PERIOD_W-1:0] l1_per_q;
  logic [DEPTH_W-1:0]  l1_dep_q;
  logic                l1_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_v_q <= 1'b0;
    end else if (en) begin
      l1_v_q <= d4_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      l1_k_q   <= d4_c.k;
      l1_len_q <= d4_c.clip ? L_MAX : d4_len;
      l1_per_q <= d4_c.per;
      l1_dep_q <= d4_c.dep;
      l1_sat_q <= d4_c.sat || d4_c.clip;
    end
  end

  // celerity = L 2^10 / T, and the sea class from h against L
  octx_t       l1_fwd;
  logic [24:0] dep20;
  logic [24:0] dep2;

  always_comb begin
    dep20       = 25'(l1_dep_q) * 25'd20;
    dep2        = {4'd0, l1_dep_q, 1'b0};
    l1_fwd.k    = l1_k_q;
    l1_fwd.len  = l1_len_q;
    l1_fwd.sat  = l1_sat_q;
    l1_fwd.clip = l1_len_q[23:6] >= {2'd0, l1_per_q};
    priority if (dep20 < {1'b0, l1_len_q}) begin
      l1_fwd.kind = SEA_SHALLOW;
    end else if (dep2 < {1'b0, l1_len_q}) begin
      l1_fwd.kind = SEA_MID;
    end else begin
      l1_fwd.kind = SEA_DEEP;
    end
  end

  logic                     d5_v;
  logic [C_W-1:0]           d5_cel;
  logic [$bits(octx_t)-1:0] d5_side;
  octx_t                    d5_c;

  wds_div #(.D_W(PERIOD_W), .Q_W(C_W), .S_W($bits(octx_t))) u_div_cel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (l1_v_q),
    .rem_i   (l1_len_q[21:6]),
    .low_i   ({l1_len_q[5:0], 10'd0}),
    .div_i   (l1_per_q),
    .side_i  (l1_fwd),
    .valid_o (d5_v),
    .quo_o   (d5_cel),
    .side_o  (d5_side)
  );

  assign d5_c = d5_side;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d5_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_rsp_q.wave_number <= d5_c.k;
      out_rsp_q.wave_length <= d5_c.len;
      out_rsp_q.celerity    <= d5_c.clip ? C_MAX : d5_cel;
      out_rsp_q.sea_kind    <= d5_c.kind;
      out_rsp_q.saturated   <= d5_c.sat || d5_c.clip;
    end
  end

endmodule

// ===== src/wds_checker.sv =====
`timescale 1ns / 1ps
`include "wave_dispersion_solver_assert.svh"
module wds_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input wds_pkg::in_t               in_req_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input wds_pkg::out_t              out_rsp_o,
  input logic                       cfg_we_i,
  input logic [wds_pkg::GRAV_W-1:0] cfg_wdata_i
);
  import wds_pkg::*;

  logic out_held;
  logic no_clip;
  logic kind_ok;

  assign out_held = out_valid_o && out_stall_i;
  assign no_clip  = (out_rsp_o.wave_number != K_MAX) && (out_rsp_o.wave_length != L_MAX)
                    && (out_rsp_o.celerity != C_MAX);
  assign kind_ok  = (out_rsp_o.sea_kind == SEA_SHALLOW) || (out_rsp_o.sea_kind == SEA_MID)
                    || (out_rsp_o.sea_kind == SEA_DEEP);

  `WDS_ASSERT(a_out_hold, out_held |=> out_valid_o && $stable(out_rsp_o), "stalled result changed")
  `WDS_ASSERT(a_in_flow, !out_held |-> !in_stall_o, "request stalled with output free")
  `WDS_ASSERT(a_kind, out_valid_o |-> kind_ok, "sea class out of range")
  `WDS_ASSERT(a_sat, (out_valid_o && no_clip) |-> !out_rsp_o.saturated, "flag without clip")

endmodule

bind wave_dispersion_solver wds_checker u_wds_checker (.*);
